>>> rtl/bsui_pkg.sv
// ----------------------------------------------------------------------------
// bsui_pkg: shared types for the bitmap set union and intersection engine
// Opcodes, status codes, sequencer types and the result record.
// ----------------------------------------------------------------------------
package bsui_pkg;

  // Default sizing of the two sets.
  localparam int VALUE_SPACE_DEF  = 4096;
  localparam int SET_CAPACITY_DEF = 128;

  // Bitmap word layout: WORD_BITS values per memory word, A half low.
  localparam int WORD_BITS   = 16;
  localparam int VALUE_W     = 12;
  localparam int TDATA_W     = 16;
  localparam int TUSER_IN_W  = 2;
  localparam int TUSER_OUT_W = 6;

  typedef enum logic [1:0] {
    OP_INS_A  = 2'd0,
    OP_INS_B  = 2'd1,
    OP_FETCH  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_ACCEPTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_OUT_RANGE = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_FETCH     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_UNION_A = 2'd0,
    PH_UNION_B = 2'd1,
    PH_INTER   = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  // What a search looks for.
  typedef enum logic [1:0] {
    FK_A      = 2'd0,
    FK_B_ONLY = 2'd1,
    FK_COMMON = 2'd2
  } find_kind_t;

  // Which search of a fetch is running.
  typedef enum logic [1:0] {
    FS_CUR    = 2'd0,
    FS_NEXT   = 2'd1,
    FS_B_ZERO = 2'd2
  } find_step_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_FIND,
    S_SCAN,
    S_ORD_RD,
    S_MAP_RD,
    S_INT_CHK,
    S_STEP,
    S_RESULT
  } state_t;

  typedef struct packed {
    status_t              status;
    logic                 has_element;
    logic [VALUE_W-1:0]   element;
    logic                 list_id;
    logic                 last_of_list;
    logic                 all_done;
  } result_t;

  // Index of the lowest set bit of a bitmap word; zero when none is set.
  function automatic logic [3:0] lowest_set(input logic [WORD_BITS-1:0] bits);
    logic [3:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/bsui_result_buf.sv
// ----------------------------------------------------------------------------
// bsui_result_buf: output register for result words
// Holds one finished result and packs it onto the master stream.
// ----------------------------------------------------------------------------
module bsui_result_buf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bsui_pkg::result_t                in_res,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // element, zero filled
  output logic [bsui_pkg::TDATA_W-1:0]     m_tdata,
  // status[2:0], has_element[3], list_id[4], all_done[5]
  output logic [bsui_pkg::TUSER_OUT_W-1:0] m_tuser,
  output logic                             m_tlast
);
  import bsui_pkg::*;

  logic    full;
  result_t held;

  // A new word may enter when the register is empty or is being drained.
  assign in_ready = !full || m_tready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (m_tready) begin
      full <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_res;
    end
  end

  // Pack the result onto the stream.
  assign m_tvalid = full;
  assign m_tdata  = {{(TDATA_W - VALUE_W){1'b0}}, held.element};
  assign m_tuser  = {held.all_done, held.list_id, held.has_element, held.status};
  assign m_tlast  = held.last_of_list;

endmodule

>>> rtl/bitmap_set_union_intersection.sv
// ----------------------------------------------------------------------------
// bitmap_set_union_intersection: set union and intersection engine
// Two membership bitmaps in one word memory, an insertion-order list of A,
// and a sequencer that walks them to emit the union and intersection lists.
// ----------------------------------------------------------------------------
// Usage: each slave word carries an opcode in s_tuser (insert A, insert B,
// fetch, clear) and a value in s_tdata[11:0]. Every slave word yields exactly
// one master word: status, has_element, list_id and all_done in m_tuser,
// the element in m_tdata[11:0], last_of_list on m_tlast.
// The block works on one word at a time. An insert reads its bitmap word,
// checks it and, when accepted, writes it back; an out-of-range insert goes
// straight to its result. A fetch runs up to three searches: bitmap scans,
// each over at most VALUE_SPACE/16 bitmap words and none when it starts past
// the end, or in the intersection list a walk that reads each A entry
// examined and then its bitmap word.
// A clear, and reset, sweep the bitmap memory one word a cycle, VALUE_SPACE/16
// words in all, during which s_tready stays low.
// A finished result sits in an output register; the block takes the next
// slave word while it waits, and holds its following result until
// m_tready drains the register.
// ----------------------------------------------------------------------------
module bitmap_set_union_intersection #(
  parameter int VALUE_SPACE  = bsui_pkg::VALUE_SPACE_DEF,
  parameter int SET_CAPACITY = bsui_pkg::SET_CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // value[11:0], zero filled
  input  logic [bsui_pkg::TDATA_W-1:0]     s_tdata,
  // operation[1:0]
  input  logic [bsui_pkg::TUSER_IN_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // element[11:0], zero filled
  output logic [bsui_pkg::TDATA_W-1:0]     m_tdata,
  // status[2:0], has_element[3], list_id[4], all_done[5]
  output logic [bsui_pkg::TUSER_OUT_W-1:0] m_tuser,
  output logic                             m_tlast
);
  import bsui_pkg::*;

  localparam int NW   = (VALUE_SPACE + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int SAW  = WAW + 1;
  localparam int MW   = 2 * WORD_BITS;
  localparam int PW   = $clog2(VALUE_SPACE + 1);
  localparam int CW   = $clog2(SET_CAPACITY + 1);
  localparam int CIW  = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int SPW  = (PW > CW) ? PW : CW;
  localparam logic [31:0]    VS32      = 32'(VALUE_SPACE);
  localparam logic [31:0]    CAP32     = 32'(SET_CAPACITY);
  localparam logic [SAW-1:0] LAST_WORD = SAW'(NW - 1);
  localparam logic [SAW-1:0] NW_S      = SAW'(NW);

  // Control registers.
  state_t           state, state_next;
  logic [SAW-1:0]   clr_addr;
  logic             clr_reply;
  logic [CW-1:0]    count_a, count_b;
  phase_t           phase;
  logic [SPW-1:0]   scan_ptr;

  // Working registers.
  op_t              op;
  logic [VALUE_W-1:0] ins_val;
  find_kind_t       f_kind;
  find_step_t       f_step;
  logic [SPW-1:0]   f_start, f_pos;
  logic             f_found;
  logic [VALUE_W-1:0] f_val;
  logic [CW-1:0]    f_idx;
  logic [SAW-1:0]   sc_addr, sw, rv_word;
  logic [3:0]       sbit;
  logic             rv;
  logic [VALUE_W-1:0] res_elem;
  result_t          res;

  // Memories.
  logic [MW-1:0]      bmap [NW];
  logic [MW-1:0]      mem_q;
  logic [VALUE_W-1:0] ord_mem [SET_CAPACITY];
  logic [VALUE_W-1:0] ord_q;

  logic               mem_rd_en, mem_wr_en;
  logic [WAW-1:0]     mem_rd_addr, mem_wr_addr;
  logic [MW-1:0]      mem_wr_data;
  logic               ord_rd_en, ord_wr_en;

  logic               push_ready;

  // Input decode.
  logic               accept;
  op_t                in_op;
  logic [VALUE_W-1:0] in_val;
  logic               in_range;
  result_t            idle_res;

  assign accept   = s_tvalid && s_tready;
  assign in_op    = op_t'(s_tuser);
  assign in_val   = s_tdata[VALUE_W-1:0];
  assign in_range = 32'(in_val) < VS32;

  // Result known at accept: out-of-range insert, clear and the done word.
  always_comb begin
    idle_res = '0;
    unique case (in_op)
      OP_INS_A, OP_INS_B: begin
        if (!in_range) begin
          idle_res.status = STAT_OUT_RANGE;
        end
      end
      OP_FETCH: begin
        if (phase == PH_DONE) begin
          idle_res.status   = STAT_FETCH;
          idle_res.list_id  = 1'b1;
          idle_res.all_done = 1'b1;
        end
      end
      OP_CLEAR: ;
    endcase
  end

  // Insert datapath.
  logic [31:0]          ins_word32;
  logic [WORD_BITS-1:0] a_half, b_half, ins_mask;
  logic                 ins_dup, ins_full;
  logic [CW-1:0]        ins_cnt;

  assign ins_word32 = 32'(ins_val) >> 4;
  assign a_half     = mem_q[WORD_BITS-1:0];
  assign b_half     = mem_q[MW-1:WORD_BITS];
  assign ins_mask   = WORD_BITS'(1) << ins_val[3:0];
  assign ins_dup    = (op == OP_INS_A) ? a_half[ins_val[3:0]] : b_half[ins_val[3:0]];
  assign ins_cnt    = (op == OP_INS_A) ? count_a : count_b;
  assign ins_full   = 32'(ins_cnt) >= CAP32;

  // Bitmap scan datapath: one word checked per cycle.
  logic [WORD_BITS-1:0] scan_bits, scan_masked;
  logic [3:0]           scan_enc;
  logic [31:0]          scan_pos32, fs_word32, start32;
  logic                 scan_hit, scan_miss, sc_issue;

  assign scan_bits   = (f_kind == FK_A) ? a_half : (b_half & ~a_half);
  assign scan_masked = (rv_word == sw) ? (scan_bits & ({WORD_BITS{1'b1}} << sbit))
                                       : scan_bits;
  assign scan_enc    = lowest_set(scan_masked);
  assign scan_pos32  = (32'(rv_word) << 4) | 32'(scan_enc);
  assign scan_hit    = rv && (|scan_masked);
  assign scan_miss   = rv && !(|scan_masked) && (rv_word == LAST_WORD);
  assign sc_issue    = sc_addr < NW_S;
  assign start32     = 32'(f_start);
  assign fs_word32   = start32 >> 4;

  // Intersection walk over the insertion-order list.
  logic          int_hit, idx_end;
  logic [CW-1:0] idx_next;
  logic [31:0]   ord_word32;

  assign int_hit    = b_half[f_val[3:0]];
  assign idx_next   = f_idx + CW'(1);
  assign idx_end    = idx_next >= count_a;
  assign ord_word32 = 32'(ord_q) >> 4;

  // Search kind for the list the current phase emits.
  find_kind_t fetch_kind;
  always_comb begin
    unique case (phase)
      PH_UNION_A: fetch_kind = FK_A;
      PH_UNION_B: fetch_kind = FK_B_ONLY;
      default:    fetch_kind = FK_COMMON;
    endcase
  end

  // Sequencer decision after each search of a fetch.
  logic           dec_launch, dec_save;
  find_kind_t     dec_kind;
  find_step_t     dec_step;
  logic [SPW-1:0] dec_start, dec_ptr;
  phase_t         dec_phase;
  result_t        dec_res;
  logic [31:0]    pos32;
  logic [VALUE_W-1:0] save_val;

  assign pos32    = 32'(f_pos);
  assign save_val = (f_kind == FK_COMMON) ? f_val : pos32[VALUE_W-1:0];

  always_comb begin
    dec_launch = 1'b0;
    dec_save   = 1'b0;
    dec_kind   = f_kind;
    dec_start  = f_pos + SPW'(1);
    dec_step   = FS_NEXT;
    dec_phase  = phase;
    dec_ptr    = scan_ptr;
    dec_res    = '0;
    dec_res.status  = STAT_FETCH;
    dec_res.element = res_elem;
    unique case (phase)
      PH_UNION_A: begin
        unique case (f_step)
          FS_CUR: begin
            if (f_found) begin
              dec_launch = 1'b1;
              dec_save   = 1'b1;
            end else begin
              // No A member left: fall through to the B-only part.
              dec_phase  = PH_UNION_B;
              dec_ptr    = '0;
              dec_launch = 1'b1;
              dec_kind   = FK_B_ONLY;
              dec_start  = '0;
              dec_step   = FS_CUR;
            end
          end
          FS_NEXT: begin
            if (f_found) begin
              dec_ptr = f_pos;
              dec_res.has_element = 1'b1;
            end else begin
              // Last A member: the union ends here unless B-only members exist.
              dec_launch = 1'b1;
              dec_kind   = FK_B_ONLY;
              dec_start  = '0;
              dec_step   = FS_B_ZERO;
            end
          end
          FS_B_ZERO: begin
            dec_res.has_element = 1'b1;
            if (f_found) begin
              dec_phase = PH_UNION_B;
              dec_ptr   = f_pos;
            end else begin
              dec_phase = PH_INTER;
              dec_ptr   = '0;
              dec_res.last_of_list = 1'b1;
            end
          end
          default: ;
        endcase
      end
      PH_UNION_B, PH_INTER: begin
        dec_res.list_id = (phase == PH_INTER);
        unique case (f_step)
          FS_CUR: begin
            if (f_found) begin
              dec_launch = 1'b1;
              dec_save   = 1'b1;
            end else begin
              // Empty remainder: one empty word closes the list.
              dec_phase = (phase == PH_INTER) ? PH_DONE : PH_INTER;
              dec_ptr   = '0;
              dec_res.last_of_list = 1'b1;
            end
          end
          FS_NEXT: begin
            dec_res.has_element = 1'b1;
            if (f_found) begin
              dec_ptr = f_pos;
            end else begin
              dec_phase = (phase == PH_INTER) ? PH_DONE : PH_INTER;
              dec_ptr   = '0;
              dec_res.last_of_list = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // A word without a list member carries a zero element.
    if (!dec_res.has_element) begin
      dec_res.element = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_WORD) begin
          state_next = clr_reply ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INS_A, OP_INS_B: state_next = in_range ? S_INS_RD : S_RESULT;
            OP_FETCH:           state_next = (phase == PH_DONE) ? S_RESULT : S_FIND;
            OP_CLEAR:           state_next = S_CLEAR;
          endcase
        end
      end
      S_INS_RD:  state_next = S_INS_CHK;
      S_INS_CHK: state_next = S_RESULT;
      S_FIND: begin
        if (f_kind == FK_COMMON) begin
          state_next = (start32 >= 32'(count_a)) ? S_STEP : S_ORD_RD;
        end else begin
          state_next = (start32 >= VS32) ? S_STEP : S_SCAN;
        end
      end
      S_SCAN:    state_next = (scan_hit || scan_miss) ? S_STEP : S_SCAN;
      S_ORD_RD:  state_next = S_MAP_RD;
      S_MAP_RD:  state_next = S_INT_CHK;
      S_INT_CHK: state_next = (int_hit || idx_end) ? S_STEP : S_ORD_RD;
      S_STEP:    state_next = dec_launch ? S_FIND : S_RESULT;
      S_RESULT:  state_next = push_ready ? S_IDLE : S_RESULT;
      default:   state_next = S_CLEAR;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    s_tready    = (state == S_IDLE);
    mem_rd_en   = 1'b0;
    mem_rd_addr = ins_word32[WAW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = ins_word32[WAW-1:0];
    mem_wr_data = mem_q;
    ord_rd_en   = 1'b0;
    ord_wr_en   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr[WAW-1:0];
        mem_wr_data = '0;
      end
      S_INS_RD: mem_rd_en = 1'b1;
      S_INS_CHK: begin
        if (!ins_dup && !ins_full) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = (op == OP_INS_A) ? (mem_q | {{WORD_BITS{1'b0}}, ins_mask})
                                         : (mem_q | {ins_mask, {WORD_BITS{1'b0}}});
          ord_wr_en   = (op == OP_INS_A);
        end
      end
      S_SCAN: begin
        mem_rd_en   = sc_issue;
        mem_rd_addr = sc_addr[WAW-1:0];
      end
      S_ORD_RD: ord_rd_en = 1'b1;
      S_MAP_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = ord_word32[WAW-1:0];
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      count_a   <= '0;
      count_b   <= '0;
      phase     <= PH_UNION_A;
      scan_ptr  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SAW'(1);
          if (clr_addr == LAST_WORD) begin
            clr_reply <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op      <= in_op;
            ins_val <= in_val;
            res     <= idle_res;
            unique case (in_op)
              OP_INS_A, OP_INS_B: ;
              OP_FETCH: begin
                f_kind  <= fetch_kind;
                f_start <= scan_ptr;
                f_step  <= FS_CUR;
              end
              OP_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                count_a   <= '0;
                count_b   <= '0;
                phase     <= PH_UNION_A;
                scan_ptr  <= '0;
              end
            endcase
          end
        end
        S_INS_CHK: begin
          if (ins_dup) begin
            res.status <= STAT_DUPLICATE;
          end else if (ins_full) begin
            res.status <= STAT_FULL;
          end else begin
            // Accepted: the emission restarts at the head of the union.
            if (op == OP_INS_A) begin
              count_a <= count_a + CW'(1);
            end else begin
              count_b <= count_b + CW'(1);
            end
            phase    <= PH_UNION_A;
            scan_ptr <= '0;
          end
        end
        S_FIND: begin
          f_found <= 1'b0;
          sc_addr <= fs_word32[SAW-1:0];
          sw      <= fs_word32[SAW-1:0];
          sbit    <= f_start[3:0];
          rv      <= 1'b0;
          f_idx   <= f_start[CW-1:0];
        end
        S_SCAN: begin
          rv      <= sc_issue;
          rv_word <= sc_addr;
          if (sc_issue) begin
            sc_addr <= sc_addr + SAW'(1);
          end
          if (scan_hit) begin
            f_found <= 1'b1;
            f_pos   <= scan_pos32[SPW-1:0];
          end
        end
        S_MAP_RD: f_val <= ord_q;
        S_INT_CHK: begin
          if (int_hit) begin
            f_found <= 1'b1;
            f_pos   <= SPW'(f_idx);
          end else begin
            f_idx <= idx_next;
          end
        end
        S_STEP: begin
          phase    <= dec_phase;
          scan_ptr <= dec_ptr;
          if (dec_save) begin
            res_elem <= save_val;
          end
          if (dec_launch) begin
            f_kind  <= dec_kind;
            f_start <= dec_start;
            f_step  <= dec_step;
          end else begin
            res <= dec_res;
          end
        end
        default: ;
      endcase
    end
  end

  // Bitmap memory: A bits in the low half, B bits in the high half.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      bmap[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_q <= bmap[mem_rd_addr];
    end
  end

  // Insertion-order memory of set A.
  always_ff @(posedge clk) begin
    if (ord_wr_en) begin
      ord_mem[count_a[CIW-1:0]] <= ins_val;
    end
    if (ord_rd_en) begin
      ord_q <= ord_mem[f_idx[CIW-1:0]];
    end
  end

  // Output register.
  bsui_result_buf u_result_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (state == S_RESULT),
    .in_ready (push_ready),
    .in_res   (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/bsui_checker.sv
// ----------------------------------------------------------------------------
// bsui_checker: port-level checks for the set union and intersection engine
// Watches the master stream and checks how result words are formed.
// ----------------------------------------------------------------------------
module bsui_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [bsui_pkg::TDATA_W-1:0]     m_tdata,
  input logic [bsui_pkg::TUSER_OUT_W-1:0] m_tuser,
  input logic                             m_tlast
);
  import bsui_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result word changed while stalled");

  // Only fetch words carry an element, and never once the lists are done.
  a_elem_fetch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> (m_tuser[2:0] == STAT_FETCH) && !m_tuser[5])
    else $error("element word without fetch status");

  // The done word is a bare fetch word on the intersection list.
  a_done_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[5] |-> (m_tuser[2:0] == STAT_FETCH) && m_tuser[4]
                               && !m_tuser[3] && !m_tlast && (m_tdata == '0))
    else $error("malformed done word");

  // Insert and clear results carry nothing besides their status.
  a_ins_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] != STAT_FETCH) |-> (m_tuser[5:3] == '0) && !m_tlast
                                                 && (m_tdata == '0))
    else $error("insert result word carries list fields");

endmodule

bind bitmap_set_union_intersection bsui_checker u_bsui_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> dv/bsui_result_checker.sv
// ----------------------------------------------------------------------------
// bsui_result_checker: scoreboard for the set union and intersection engine
// Watches both stream channels, keeps its own copy of the two sets and the
// emission sequencer, predicts one result word per accepted input word and
// compares every returned word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bsui_result_checker #(
  parameter int VALUE_SPACE  = bsui_pkg::VALUE_SPACE_DEF,
  parameter int SET_CAPACITY = bsui_pkg::SET_CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  // value[11:0], zero filled
  input  logic [bsui_pkg::TDATA_W-1:0]     s_tdata,
  // operation[1:0]
  input  logic [bsui_pkg::TUSER_IN_W-1:0]  s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  // element[11:0], zero filled
  input  logic [bsui_pkg::TDATA_W-1:0]     m_tdata,
  // status[2:0], has_element[3], list_id[4], all_done[5]
  input  logic [bsui_pkg::TUSER_OUT_W-1:0] m_tuser,
  input  logic                             m_tlast,
  output int                               mismatches,
  output int                               outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import bsui_pkg::*;

  // Shadow copy of the engine state.
  bit               in_a [VALUE_SPACE];
  bit               in_b [VALUE_SPACE];
  logic [VALUE_W-1:0] a_order [SET_CAPACITY];
  int               size_a;
  int               size_b;
  phase_t           phase;
  int               scan_ptr;

  // Predicted result words, oldest first.
  result_t          pending_results [$];
  int               results_seen;

  function automatic void empty_sets();
    for (int i = 0; i < VALUE_SPACE; i++) begin
      in_a[i] = 1'b0;
      in_b[i] = 1'b0;
    end
    size_a   = 0;
    size_b   = 0;
    phase    = PH_UNION_A;
    scan_ptr = 0;
  endfunction

  // Lowest member of A at or above start; VALUE_SPACE when there is none.
  function automatic int next_in_a(int start);
    for (int v = start; v < VALUE_SPACE; v++) begin
      if (in_a[v]) return v;
    end
    return VALUE_SPACE;
  endfunction

  // Lowest member of B that is not in A, at or above start.
  function automatic int next_b_only(int start);
    for (int v = start; v < VALUE_SPACE; v++) begin
      if (in_b[v] && !in_a[v]) return v;
    end
    return VALUE_SPACE;
  endfunction

  // Next insertion index of A at or above start whose value is also in B.
  function automatic int next_common(int start);
    for (int i = start; i < size_a; i++) begin
      if (in_b[a_order[i]]) return i;
    end
    return size_a;
  endfunction

  // Next word of the union list, then the intersection list, then done.
  function automatic result_t fetch_next();
    result_t res;
    int      x;
    res        = '0;
    res.status = STAT_FETCH;
    if (phase == PH_UNION_A) begin
      x = next_in_a(scan_ptr);
      if (x < VALUE_SPACE) begin
        res.has_element = 1'b1;
        res.element     = VALUE_W'(x);
        if (next_in_a(x + 1) < VALUE_SPACE) begin
          scan_ptr = x + 1;
        end else if (next_b_only(0) < VALUE_SPACE) begin
          phase    = PH_UNION_B;
          scan_ptr = 0;
        end else begin
          phase            = PH_INTER;
          scan_ptr         = 0;
          res.last_of_list = 1'b1;
        end
        return res;
      end
      phase    = PH_UNION_B;
      scan_ptr = 0;
    end
    if (phase == PH_UNION_B) begin
      x = next_b_only(scan_ptr);
      if (x < VALUE_SPACE) begin
        res.has_element = 1'b1;
        res.element     = VALUE_W'(x);
        if (next_b_only(x + 1) >= VALUE_SPACE) begin
          res.last_of_list = 1'b1;
          phase            = PH_INTER;
          scan_ptr         = 0;
        end else begin
          scan_ptr = x + 1;
        end
      end else begin
        // The B-only part is empty: one empty word closes the union list.
        res.last_of_list = 1'b1;
        phase            = PH_INTER;
        scan_ptr         = 0;
      end
      return res;
    end
    res.list_id = 1'b1;
    if (phase == PH_INTER) begin
      x = next_common(scan_ptr);
      if (x < size_a) begin
        res.has_element = 1'b1;
        res.element     = a_order[x];
        if (next_common(x + 1) >= size_a) begin
          res.last_of_list = 1'b1;
          phase            = PH_DONE;
          scan_ptr         = 0;
        end else begin
          scan_ptr = x + 1;
        end
      end else begin
        res.last_of_list = 1'b1;
        phase            = PH_DONE;
        scan_ptr         = 0;
      end
      return res;
    end
    // Both lists are out; every further fetch only says so.
    res.all_done = 1'b1;
    return res;
  endfunction

  // Result word of one accepted request, with the state update it causes.
  function automatic result_t predict_set_op(op_t op, logic [VALUE_W-1:0] value);
    result_t res;
    bit      present;
    int      count;
    res = '0;
    case (op)
      OP_FETCH: begin
        res = fetch_next();
      end
      OP_CLEAR: begin
        empty_sets();
        res.status = STAT_ACCEPTED;
      end
      default: begin
        count = (op == OP_INS_A) ? size_a : size_b;
        if (int'(value) >= VALUE_SPACE) begin
          res.status = STAT_OUT_RANGE;
        end else begin
          present = (op == OP_INS_A) ? in_a[value] : in_b[value];
          if (present) begin
            res.status = STAT_DUPLICATE;
          end else if (count >= SET_CAPACITY) begin
            res.status = STAT_FULL;
          end else begin
            // An accepted insert restarts emission at the head of the union.
            if (op == OP_INS_A) begin
              in_a[value]     = 1'b1;
              a_order[size_a] = value;
              size_a++;
            end else begin
              in_b[value] = 1'b1;
              size_b++;
            end
            phase      = PH_UNION_A;
            scan_ptr   = 0;
            res.status = STAT_ACCEPTED;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] result %0d: %s is %0d, expected %0d",
             $realtime, results_seen, what, got, want);
    mismatches++;
  endtask

  // Compare returned words first, then record the new request.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      empty_sets();
      pending_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("word with nothing outstanding, status", int'(m_tuser[2:0]), -1);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser[2:0] != want.status)
            report_mismatch("status", int'(m_tuser[2:0]), int'(want.status));
          if (m_tuser[3] != want.has_element)
            report_mismatch("has_element", int'(m_tuser[3]), int'(want.has_element));
          if (m_tdata[VALUE_W-1:0] != want.element)
            report_mismatch("element", int'(m_tdata[VALUE_W-1:0]), int'(want.element));
          if (m_tuser[4] != want.list_id)
            report_mismatch("list_id", int'(m_tuser[4]), int'(want.list_id));
          if (m_tlast != want.last_of_list)
            report_mismatch("last_of_list", int'(m_tlast), int'(want.last_of_list));
          if (m_tuser[5] != want.all_done)
            report_mismatch("all_done", int'(m_tuser[5]), int'(want.all_done));
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_set_op(op_t'(s_tuser),
                                                 s_tdata[VALUE_W-1:0]));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

>>> dv/tb_bitmap_set_union_intersection.sv
// ----------------------------------------------------------------------------
// tb_bitmap_set_union_intersection: stimulus and verdict for the set engine
// Drives directed requests over the set edge cases, then randomized sessions
// of clear, inserts and fetches with random back-pressure on both sides. A
// separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_bitmap_set_union_intersection;

  timeunit 1ns;
  timeprecision 1ps;

  import bsui_pkg::*;

  localparam int RANDOM_WORDS = 1750;
  localparam int QUIET_LIMIT  = 20000;
  localparam int SETTLE_CYCLES = 64;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // value[11:0], zero filled
  logic [TDATA_W-1:0]     s_tdata = '0;
  // operation[1:0]
  logic [TUSER_IN_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // element[11:0], zero filled
  logic [TDATA_W-1:0]     m_tdata;
  // status[2:0], has_element[3], list_id[4], all_done[5]
  logic [TUSER_OUT_W-1:0] m_tuser;
  logic                   m_tlast;

  int mismatches;
  int outstanding;
  int words_sent = 0;
  int tx_idle_pct = 18;
  int rx_idle_pct = 63;
  int quiet_cycles = 0;

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bitmap_set_union_intersection DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  bsui_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // End the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_bitmap_set_union_intersection failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold off the sender until every predicted word has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Send one request word; called and returning at a falling edge.
  task automatic send_word(input op_t op, input logic [VALUE_W-1:0] value);
    // Switch the idle pattern by how far the run has come.
    if (words_sent == RANDOM_WORDS / 3) begin
      drain_results();
      tx_idle_pct = 63;
      rx_idle_pct = 18;
    end else if (words_sent == 2 * RANDOM_WORDS / 3) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(value);
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // One well-formed session: clear, load both sets, then walk the lists.
  task automatic run_session();
    int  span;
    int  left_a;
    int  left_b;
    int  n_fetch;
    bit  fill;
    send_word(OP_CLEAR, VALUE_W'($urandom_range(0, 4095)));
    case ($urandom_range(0, 2))
      0: span = 16;
      1: span = 64;
      default: span = 4096;
    endcase
    left_a = $urandom_range(0, 12);
    left_b = $urandom_range(0, 12);
    fill   = ($urandom_range(0, 9) == 0);
    // Now and then one set is pushed past its capacity.
    if (fill) begin
      span = 4096;
      if ($urandom_range(0, 1)) left_a = SET_CAPACITY_DEF + 4;
      else left_b = SET_CAPACITY_DEF + 4;
    end
    n_fetch = fill ? 24 : 2 * left_a + left_b + 4;
    while (left_a + left_b > 0) begin
      if (left_a > 0 && (left_b == 0 || $urandom_range(0, 1))) begin
        send_word(OP_INS_A, VALUE_W'($urandom_range(0, span - 1)));
        left_a--;
      end else begin
        send_word(OP_INS_B, VALUE_W'($urandom_range(0, span - 1)));
        left_b--;
      end
    end
    // Fetch, past the end of both lists unless a set was filled, with the odd insert mid-stream.
    repeat (n_fetch) begin
      if ($urandom_range(0, 14) == 0) begin
        send_word($urandom_range(0, 1) ? OP_INS_A : OP_INS_B,
                  VALUE_W'($urandom_range(0, span - 1)));
      end
      send_word(OP_FETCH, VALUE_W'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    int noise;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Empty sets: empty union word, empty intersection
    // word, then the done word.
    send_word(OP_FETCH, 12'hFFF);
    send_word(OP_FETCH, 12'h000);
    send_word(OP_FETCH, 12'h000);
    // Value extremes, duplicates in both sets, alternating bit patterns.
    send_word(OP_INS_A, 12'h000);
    send_word(OP_INS_A, 12'hFFF);
    send_word(OP_INS_A, 12'h000);
    send_word(OP_INS_B, 12'hFFF);
    send_word(OP_INS_B, 12'hAAA);
    send_word(OP_INS_B, 12'h555);
    send_word(OP_INS_B, 12'h555);
    send_word(OP_FETCH, 12'h000);
    send_word(OP_FETCH, 12'h000);
    // An accepted insert in mid-emission restarts the union list.
    send_word(OP_INS_A, 12'h555);
    repeat (5) send_word(OP_FETCH, 12'h000);
    // A refused insert leaves emission where it was.
    send_word(OP_INS_A, 12'h555);
    repeat (3) send_word(OP_FETCH, 12'h000);
    // Clear empties everything and emission starts over.
    send_word(OP_CLEAR, 12'hFFF);
    send_word(OP_FETCH, 12'h000);
    send_word(OP_FETCH, 12'h000);

    // Random part: mostly sessions, some unstructured noise.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 75) begin
        run_session();
      end else begin
        noise = $urandom_range(1, 8);
        repeat (noise) begin
          send_word(op_t'($urandom_range(0, 3)), VALUE_W'($urandom_range(0, 4095)));
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_bitmap_set_union_intersection passed");
    end else begin
      $display("tb_bitmap_set_union_intersection failed");
    end
    $finish;
  end

endmodule
